FILE: hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants, widths and controller/datapath command and status types
// for the segmented prime sieve counter.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Store depths
  localparam int BASE_MAX = 65536;
  localparam int SEG_MAX  = 65536;

  // Field widths
  localparam int LOW_W = 30;
  localparam int BB_W  = 16;
  localparam int CNT_W = 18;

  localparam logic [BB_W-1:0] BASE_RESET = 16'd17320;

  // Derived widths
  localparam int BASE_AW = $clog2(BASE_MAX);
  localparam int SEG_AW  = $clog2(SEG_MAX);
  localparam int LEN_W   = SEG_AW + 1;
  localparam int K_W     = (BASE_AW > SEG_AW) ? BASE_AW : SEG_AW;
  localparam int M_W     = BB_W + 1;
  localparam int J_W     = $clog2(SEG_MAX + BASE_MAX);
  localparam int STEP_W  = $clog2(LOW_W);

  typedef struct packed {
    logic start;
    logic check;
    logic fill;
    logic prime_rd;
    logic rem_start;
    logic bmark;
    logic smark;
    logic c_inc;
    logic count;
    logic load_out;
  } sps_cmd_t;

  typedef struct packed {
    logic err;
    logic sweep_last;
    logic is_prime;
    logic rem_done;
    logic bmark_more;
    logic smark_more;
    logic c_last;
    logic out_free;
  } sps_status_t;

endpackage

FILE: hw/rtl/sps_in_if.sv
// ----------------------------------------------------------------------------
// sps_in_if
// Job request channel: segment bounds and base-count flag.
// ----------------------------------------------------------------------------
interface sps_in_if import sps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LOW_W-1:0] seg_low;
  logic [LOW_W-1:0] seg_high;
  logic             count_base;

  modport source (output valid, seg_low, seg_high, count_base, input ready);
  modport sink   (input valid, seg_low, seg_high, count_base, output ready);
endinterface

FILE: hw/rtl/sps_out_if.sv
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: prime count and range error flag.
// ----------------------------------------------------------------------------
interface sps_out_if import sps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] prime_count;
  logic             range_error;

  modport source (output valid, prime_count, range_error, input ready);
  modport sink   (input valid, prime_count, range_error, output ready);
endinterface

FILE: hw/rtl/segmented_prime_sieve_counter.sv
// A refused job goes from the check state straight to the done state and loads the result register.
// A sieved job fills both stores, then for each base candidate reads its mark and,
// on a prime, runs the remainder unit and strikes base and segment multiples,
// then sweeps both single-port bit stores to count.
// One job at a time; the next request is taken once the result is registered.
// Reset (async, active low) clears control and sets base_bound to 17320.
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter
// Segmented sieve of Eratosthenes: sieve 2..base_bound in a base bit store,
// strike the multiples of every base prime from a segment store, and count
// the survivors of the segment (plus the base primes on request).
// ----------------------------------------------------------------------------
module segmented_prime_sieve_counter import sps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [BB_W-1:0] cfg_wdata_i,
  sps_in_if.sink          req_i,
  sps_out_if.source       rsp_o
);

  // Command and status between the sequencer and the datapath
  sps_cmd_t    cmd;
  sps_status_t st;
  logic        in_ready;

  // Sequencer: accepts one request, then steps through
  //   check -> fill both stores -> per base candidate: read mark,
  //   on a prime: remainder, strike base multiples, strike segment
  //   multiples -> count sweep -> load result register.
  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: holds the base_bound register, the job fields, both
  // 64K x 1 stores, the remainder unit and the result register that
  // holds a finished result until the sink takes it.
  sps_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .seg_low_i     (req_i.seg_low),
    .seg_high_i    (req_i.seg_high),
    .count_base_i  (req_i.count_base),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .prime_count_o (rsp_o.prime_count),
    .range_error_o (rsp_o.range_error),
    .cmd_i         (cmd),
    .st_o          (st)
  );

  // Take a request only while the sequencer is idle
  assign req_i.ready = in_ready;

endmodule

FILE: hw/rtl/sps_rem.sv
// ----------------------------------------------------------------------------
// sps_rem
// Iterative restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sps_rem import sps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LOW_W-1:0] dividend_i,
  input  logic [BB_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [BB_W-1:0]  rem_o
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LOW_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [LOW_W-1:0]  dvd_q;
  logic [BB_W-1:0]   div_q;
  logic [BB_W-1:0]   rem_q;
  logic [BB_W:0]     trial;
  logic [BB_W:0]     trial_sub;
  logic [BB_W-1:0]   rem_d;

  always_comb begin
    trial     = {rem_q, dvd_q[LOW_W-1]};
    trial_sub = trial - {1'b0, div_q};
    // subtract when the divisor fits
    rem_d     = (trial >= {1'b0, div_q}) ? trial_sub[BB_W-1:0] : trial[BB_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[LOW_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// Job sequencer: range check, store fill, per-prime marking, count sweep.
// ----------------------------------------------------------------------------
module sps_ctrl import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sps_status_t st_i,
  output sps_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PCHK  = 4'd4;
  localparam logic [3:0] S_REM   = 4'd5;
  localparam logic [3:0] S_BMARK = 4'd6;
  localparam logic [3:0] S_SMARK = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_COUNT = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = st_i.err ? S_DONE : S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (st_i.sweep_last) state_d = S_PRD;
      end
      S_PRD: begin
        cmd_o.prime_rd = 1'b1;
        state_d        = S_PCHK;
      end
      S_PCHK: begin
        if (st_i.is_prime) begin
          cmd_o.rem_start = 1'b1;
          state_d         = S_REM;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_REM: begin
        if (st_i.rem_done) state_d = S_BMARK;
      end
      S_BMARK: begin
        cmd_o.bmark = 1'b1;
        if (!st_i.bmark_more) state_d = S_SMARK;
      end
      S_SMARK: begin
        cmd_o.smark = 1'b1;
        if (!st_i.smark_more) state_d = S_NEXT;
      end
      S_NEXT: begin
        if (st_i.c_last) begin
          state_d = S_COUNT;
        end else begin
          cmd_o.c_inc = 1'b1;
          state_d     = S_PRD;
        end
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
        if (st_i.sweep_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: hw/rtl/sps_datapath.sv
// ----------------------------------------------------------------------------
// sps_datapath
// Job registers, base and segment bit stores, prime walk counters,
// remainder unit, count accumulator and result register.
// ----------------------------------------------------------------------------
module sps_datapath import sps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BB_W-1:0]  cfg_wdata_i,
  input  logic [LOW_W-1:0] seg_low_i,
  input  logic [LOW_W-1:0] seg_high_i,
  input  logic             count_base_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [CNT_W-1:0] prime_count_o,
  output logic             range_error_o,
  input  sps_cmd_t         cmd_i,
  output sps_status_t      st_o
);

  // configuration
  logic [BB_W-1:0]  bb_q;

  // job registers
  logic [LOW_W-1:0] lo_q;
  logic [LOW_W-1:0] hi_q;
  logic             cb_q;
  logic             err_q;
  logic [LEN_W-1:0] len_q;

  // walk counters
  logic [K_W-1:0]   k_q;
  logic [BB_W-1:0]  c_q;
  logic [M_W-1:0]   m_q;
  logic [J_W-1:0]   j_q;

  // count pipeline
  logic             pend_q;
  logic [K_W-1:0]   kp_q;
  logic [CNT_W-1:0] acc_q;

  // result register
  logic             out_valid_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_err_q;

  // stores
  logic base_mem [BASE_MAX];
  logic seg_mem  [SEG_MAX];
  logic base_rd_q;
  logic seg_rd_q;

  logic               base_we, base_wd;
  logic [BASE_AW-1:0] base_addr;
  logic               seg_we, seg_wd;
  logic [SEG_AW-1:0]  seg_addr;

  // range check
  logic [LOW_W-1:0] diff;
  logic             err_c;
  logic [LEN_W-1:0] len_c;

  // remainder unit
  logic             rem_done;
  logic [BB_W-1:0]  rem_val;
  logic [BB_W-1:0]  first_off;

  logic             sweep_last;
  logic             bmark_more;
  logic             smark_more;
  logic             base_hit;
  logic             seg_hit;

  always_comb begin
    diff  = hi_q - lo_q;
    err_c = (bb_q < BB_W'(2)) ||
            ({1'b0, bb_q} >= (BB_W+1)'(BASE_MAX)) ||
            (hi_q < lo_q) ||
            (lo_q <= LOW_W'(bb_q)) ||
            (diff >= LOW_W'(SEG_MAX));
    len_c = diff[LEN_W-1:0] + LEN_W'(1);
  end

  assign sweep_last = (k_q >= K_W'(bb_q)) &&
                      (({1'b0, k_q} + (K_W+1)'(1)) >= (K_W+1)'(len_q));
  assign bmark_more = (m_q <= M_W'(bb_q));
  assign smark_more = (j_q < J_W'(len_q));
  assign first_off  = (rem_val == '0) ? '0 : (c_q - rem_val);

  sps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.rem_start),
    .dividend_i (lo_q),
    .divisor_i  (c_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // store port selection
  always_comb begin
    base_we = cmd_i.fill || (cmd_i.bmark && bmark_more);
    base_wd = cmd_i.fill;
    if (cmd_i.fill || cmd_i.count) begin
      base_addr = k_q[BASE_AW-1:0];
    end else if (cmd_i.bmark) begin
      base_addr = m_q[BASE_AW-1:0];
    end else begin
      base_addr = c_q[BASE_AW-1:0];
    end

    seg_we = (cmd_i.fill && ({1'b0, k_q} < (K_W+1)'(len_q))) ||
             (cmd_i.smark && smark_more);
    seg_wd = cmd_i.fill;
    if (cmd_i.fill || cmd_i.count) begin
      seg_addr = k_q[SEG_AW-1:0];
    end else begin
      seg_addr = j_q[SEG_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[base_addr] <= base_wd;
    base_rd_q <= base_mem[base_addr];
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[seg_addr] <= seg_wd;
    seg_rd_q <= seg_mem[seg_addr];
  end

  // count contributions; mask entries outside the written ranges
  assign base_hit = cb_q && (kp_q >= K_W'(2)) && (kp_q <= K_W'(bb_q)) && base_rd_q;
  assign seg_hit  = ({1'b0, kp_q} < (K_W+1)'(len_q)) && seg_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q        <= BASE_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) bb_q <= cfg_wdata_i;
      pend_q <= cmd_i.count;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kp_q <= k_q;

    if (cmd_i.start) begin
      lo_q  <= seg_low_i;
      hi_q  <= seg_high_i;
      cb_q  <= count_base_i;
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + CNT_W'(base_hit) + CNT_W'(seg_hit);
    end

    if (cmd_i.check) begin
      err_q <= err_c;
      len_q <= len_c;
      k_q   <= '0;
      c_q   <= BB_W'(2);
    end else if (cmd_i.fill || cmd_i.count) begin
      k_q <= sweep_last ? '0 : (k_q + K_W'(1));
    end else if (cmd_i.c_inc) begin
      c_q <= c_q + BB_W'(1);
    end

    // base multiples start at twice the prime
    if (cmd_i.rem_start) begin
      m_q <= {c_q, 1'b0};
    end else if (cmd_i.bmark && bmark_more) begin
      m_q <= m_q + M_W'(c_q);
    end

    // segment multiples start at the first multiple at or above seg_low
    if (rem_done) begin
      j_q <= J_W'(first_off);
    end else if (cmd_i.smark && smark_more) begin
      j_q <= j_q + J_W'(c_q);
    end

    if (cmd_i.load_out) begin
      out_count_q <= err_q ? '0 : acc_q;
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    st_o            = '0;
    st_o.err        = err_c;
    st_o.sweep_last = sweep_last;
    st_o.is_prime   = base_rd_q;
    st_o.rem_done   = rem_done;
    st_o.bmark_more = bmark_more;
    st_o.smark_more = smark_more;
    st_o.c_last     = (c_q == bb_q);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign prime_count_o = out_count_q;
  assign range_error_o = out_err_q;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (rem_val < c_q))
    else $error("remainder not below divisor");

  a_bmark_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.bmark && bmark_more) |-> (m_q >= {c_q, 1'b0}))
    else $error("base mark below twice the prime");

  a_err_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_count_q == '0))
    else $error("refused job reports nonzero count");
`endif

endmodule
